// File: src/smau_pkg.sv
package smau_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int INDEX_BITS   = 8;
    localparam int DEGREE_BITS  = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);

    // previous operand index code meaning "none yet"
    localparam logic [INDEX_BITS:0] NO_PREV = {1'b1, {INDEX_BITS{1'b0}}};

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_OPERAND = 2'd2,
        ACT_FINISH  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_MUL  = 2'd0,
        MODE_DIV  = 2'd1,
        MODE_GCD  = 2'd2,
        MODE_TEST = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OPER,
        S_PRUNE,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_DROP,
        CMD_SET
    } cmd_t;

    typedef enum logic [2:0] {
        C_HOLD,
        C_LOAD,
        C_LEFT,
        C_RIGHT,
        C_SET
    } cell_op_t;

    typedef struct packed {
        action_t                 action;
        logic [INDEX_BITS-1:0]   var_index;
        logic [DEGREE_BITS-1:0]  var_degree;
    } in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]   out_index;
        logic [DEGREE_BITS-1:0]  out_degree;
        logic                    entry_valid;
        logic                    is_divisible;
        logic                    overflow_flag;
        logic                    order_error;
        logic                    last_entry;
    } out_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]   idx;
        logic [DEGREE_BITS-1:0]  deg;
        logic                    matched;
    } entry_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]   idx;
        logic [DEGREE_BITS-1:0]  deg;
        logic                    mark;
    } cell_bus_t;

    typedef struct packed {
        logic hit;
        logic lower;
    } cell_flags_t;

endpackage

// File: src/smau_cell.sv
module smau_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  smau_pkg::cell_op_t                  op,
    input  smau_pkg::cell_bus_t                 bus,
    input  smau_pkg::entry_t                    left,
    input  smau_pkg::entry_t                    right,
    input  logic                                clear_marks,
    input  logic                                occupied,
    input  logic [smau_pkg::INDEX_BITS-1:0]     key,
    output smau_pkg::entry_t                    entry,
    output smau_pkg::cell_flags_t               flags
);

    logic [smau_pkg::INDEX_BITS-1:0]  idx_reg, idx_next;
    logic [smau_pkg::DEGREE_BITS-1:0] deg_reg, deg_next;
    logic                             matched_reg, matched_next;

    always_comb
    begin
        idx_next     = idx_reg;
        deg_next     = deg_reg;
        matched_next = matched_reg;
        unique case (op)
            smau_pkg::C_HOLD:
            begin
            end
            smau_pkg::C_LOAD:
            begin
                idx_next     = bus.idx;
                deg_next     = bus.deg;
                matched_next = 1'b0;
            end
            smau_pkg::C_LEFT:
            begin
                idx_next     = left.idx;
                deg_next     = left.deg;
                matched_next = left.matched;
            end
            smau_pkg::C_RIGHT:
            begin
                idx_next     = right.idx;
                deg_next     = right.deg;
                matched_next = right.matched;
            end
            smau_pkg::C_SET:
            begin
                deg_next     = bus.deg;
                matched_next = matched_reg | bus.mark;
            end
            default:
            begin
            end
        endcase
        if (clear_marks)
        begin
            matched_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= 1'b0;
        end
        else
        begin
            matched_reg <= matched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        deg_reg <= deg_next;
    end

    assign entry.idx     = idx_reg;
    assign entry.deg     = deg_reg;
    assign entry.matched = matched_reg;

    assign flags.hit   = occupied && (idx_reg == key);
    assign flags.lower = occupied && (idx_reg < key);

endmodule

// File: src/sparse_monomial_arith_unit_top.sv
// Sparse monomial arithmetic unit.
// Input: an item is taken when start is high and busy is low. Clear and load
// items leave the block idle, so a new item may follow in the next cycle. An operand
// item holds busy through S_OPER: the cell row matches the index in the accept
// cycle, and the degree update, insert or removal is applied in S_OPER.
// Finish: in gcd mode the unmarked pairs are removed first, one per cycle,
// in S_PRUNE. Then the results leave one per cycle on result, marked by
// result_strobe, the first one once S_EMIT has loaded the result registers
// (gcd: after pruning); min(count, 16) results, or one empty result when the
// list is empty. busy drops with the last result. The receiver cannot stall:
// each result is valid for exactly one cycle.
// Configuration: op_mode is written on cfg_valid & cfg_ready; the user must
// write it only while idle, which the block does not enforce. cfg_ready is always high.
// Reset: list empty, overflow and order flags cleared, divisible flag set, op_mode multiply.
// The pair storage holds no defined value until loaded and needs no clearing pass.
module sparse_monomial_arith_unit_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  smau_pkg::in_t   item,
    output logic            result_strobe,
    output smau_pkg::out_t  result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_data
);

    localparam int N  = smau_pkg::MAX_ENTRIES;
    localparam int CW = smau_pkg::CNT_W;
    localparam int IB = smau_pkg::INDEX_BITS;
    localparam int DB = smau_pkg::DEGREE_BITS;

    smau_pkg::state_t           state_reg, state_next;
    smau_pkg::mode_t            mode_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic                       div_reg, div_next;
    logic                       ovf_reg, ovf_next;
    logic                       ord_reg, ord_next;
    logic [IB:0]                prev_reg, prev_next;
    logic [IB-1:0]              op_v_reg, op_v_next;
    logic [DB-1:0]              op_d_reg, op_d_next;
    logic                       hit_reg, hit_next;
    logic [CW-1:0]              hit_pos_reg, hit_pos_next;
    logic [CW-1:0]              ins_pos_reg, ins_pos_next;
    logic [DB-1:0]              cur_deg_reg, cur_deg_next;
    logic [CW-1:0]              emit_reg, emit_next;
    logic                       strobe_reg, strobe_next;
    smau_pkg::out_t             result_reg, result_next;

    smau_pkg::entry_t           entries   [N];
    smau_pkg::cell_flags_t      flags     [N];
    smau_pkg::cell_op_t         cell_op   [N];
    logic [N-1:0]               occupied;

    smau_pkg::cmd_t             cmd;
    logic [CW-1:0]              cmd_pos;
    smau_pkg::cell_bus_t        bus;
    logic                       clear_marks;

    logic                       hit_any;
    logic [CW-1:0]              hit_pos;
    logic [DB-1:0]              hit_deg;
    logic                       low_any;
    logic [CW-1:0]              ins_pos;
    logic                       unm_any;
    logic [CW-1:0]              unm_pos;
    smau_pkg::entry_t           emit_entry;
    logic [CW-1:0]              n_emit;
    logic                       emit_last;

    logic [DB:0]                deg_sum;
    logic                       upd_en;
    logic                       upd_mark;
    logic [DB-1:0]              upd_deg;
    logic                       list_full;

    // ---------------- cell row ----------------
    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            smau_pkg::entry_t left_in, right_in;

            if (k == 0)
            begin : g_first
                assign left_in = '0;
            end
            else
            begin : g_mid_l
                assign left_in = entries[k-1];
            end
            if (k == N - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = entries[k+1];
            end

            assign occupied[k] = (CW'(k) < count_reg);

            always_comb
            begin
                cell_op[k] = smau_pkg::C_HOLD;
                unique case (cmd)
                    smau_pkg::CMD_NONE:
                    begin
                    end
                    smau_pkg::CMD_INSERT:
                    begin
                        if (CW'(k) == cmd_pos)
                        begin
                            cell_op[k] = smau_pkg::C_LOAD;
                        end
                        else if (CW'(k) > cmd_pos)
                        begin
                            cell_op[k] = smau_pkg::C_LEFT;
                        end
                    end
                    smau_pkg::CMD_DROP:
                    begin
                        if (CW'(k) >= cmd_pos)
                        begin
                            cell_op[k] = smau_pkg::C_RIGHT;
                        end
                    end
                    smau_pkg::CMD_SET:
                    begin
                        if (CW'(k) == cmd_pos)
                        begin
                            cell_op[k] = smau_pkg::C_SET;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            smau_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (cell_op[k]),
                .bus         (bus),
                .left        (left_in),
                .right       (right_in),
                .clear_marks (clear_marks),
                .occupied    (occupied[k]),
                .key         (item.var_index),
                .entry       (entries[k]),
                .flags       (flags[k])
            );
        end
    endgenerate

    // ---------------- searches over the row ----------------
    always_comb
    begin
        hit_any    = 1'b0;
        hit_pos    = '0;
        hit_deg    = '0;
        low_any    = 1'b0;
        ins_pos    = count_reg;
        unm_any    = 1'b0;
        unm_pos    = '0;
        emit_entry = '0;
        for (int i = 0; i < N; i++)
        begin
            if (flags[i].hit && !hit_any)
            begin
                hit_any = 1'b1;
                hit_pos = CW'(i);
                hit_deg = entries[i].deg;
            end
            if (flags[i].lower && !low_any)
            begin
                low_any = 1'b1;
                ins_pos = CW'(i);
            end
            if (occupied[i] && !entries[i].matched && !unm_any)
            begin
                unm_any = 1'b1;
                unm_pos = CW'(i);
            end
            if (CW'(i) == emit_reg)
            begin
                emit_entry = entries[i];
            end
        end
    end

    always_comb
    begin
        if (int'(count_reg) < smau_pkg::RESULT_LIMIT)
        begin
            n_emit = count_reg;
        end
        else
        begin
            n_emit = CW'(smau_pkg::RESULT_LIMIT);
        end
    end

    assign list_full = (int'(count_reg) >= N);
    assign deg_sum   = {1'b0, cur_deg_reg} + {1'b0, op_d_reg};

    // ---------------- control ----------------
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        div_next     = div_reg;
        ovf_next     = ovf_reg;
        ord_next     = ord_reg;
        prev_next    = prev_reg;
        op_v_next    = op_v_reg;
        op_d_next    = op_d_reg;
        hit_next     = hit_reg;
        hit_pos_next = hit_pos_reg;
        ins_pos_next = ins_pos_reg;
        cur_deg_next = cur_deg_reg;
        emit_next    = emit_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        cmd          = smau_pkg::CMD_NONE;
        cmd_pos      = '0;
        bus          = '0;
        clear_marks  = 1'b0;
        upd_en       = 1'b0;
        upd_mark     = 1'b0;
        upd_deg      = '0;
        emit_last    = 1'b0;

        unique case (state_reg)
            smau_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (item.action)
                        smau_pkg::ACT_CLEAR:
                        begin
                            count_next  = '0;
                            div_next    = 1'b1;
                            ovf_next    = 1'b0;
                            ord_next    = 1'b0;
                            prev_next   = smau_pkg::NO_PREV;
                            clear_marks = 1'b1;
                        end
                        smau_pkg::ACT_LOAD:
                        begin
                            if (list_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                cmd        = smau_pkg::CMD_INSERT;
                                cmd_pos    = count_reg;
                                bus.idx    = item.var_index;
                                bus.deg    = item.var_degree;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        smau_pkg::ACT_OPERAND:
                        begin
                            if (prev_reg != smau_pkg::NO_PREV
                                && {1'b0, item.var_index} >= prev_reg)
                            begin
                                ord_next = 1'b1;
                            end
                            prev_next    = {1'b0, item.var_index};
                            op_v_next    = item.var_index;
                            op_d_next    = item.var_degree;
                            hit_next     = hit_any;
                            hit_pos_next = hit_pos;
                            ins_pos_next = ins_pos;
                            cur_deg_next = hit_deg;
                            state_next   = smau_pkg::S_OPER;
                        end
                        smau_pkg::ACT_FINISH:
                        begin
                            emit_next = '0;
                            if (mode_reg == smau_pkg::MODE_GCD)
                            begin
                                state_next = smau_pkg::S_PRUNE;
                            end
                            else
                            begin
                                state_next = smau_pkg::S_EMIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            smau_pkg::S_OPER:
            begin
                if (!hit_reg || cur_deg_reg < op_d_reg)
                begin
                    div_next = 1'b0;
                end
                unique case (mode_reg)
                    smau_pkg::MODE_MUL:
                    begin
                        if (hit_reg)
                        begin
                            upd_en  = 1'b1;
                            upd_deg = deg_sum[DB] ? {DB{1'b1}} : deg_sum[DB-1:0];
                            if (deg_sum[DB])
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        else if (op_d_reg != '0)
                        begin
                            if (list_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                cmd        = smau_pkg::CMD_INSERT;
                                cmd_pos    = ins_pos_reg;
                                bus.idx    = op_v_reg;
                                bus.deg    = op_d_reg;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    smau_pkg::MODE_DIV:
                    begin
                        if (hit_reg)
                        begin
                            upd_en  = 1'b1;
                            upd_deg = (cur_deg_reg > op_d_reg) ? cur_deg_reg - op_d_reg : '0;
                        end
                    end
                    smau_pkg::MODE_GCD:
                    begin
                        if (hit_reg)
                        begin
                            upd_en   = 1'b1;
                            upd_mark = 1'b1;
                            upd_deg  = (cur_deg_reg < op_d_reg) ? cur_deg_reg : op_d_reg;
                        end
                    end
                    smau_pkg::MODE_TEST:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
                // zero degree removes the pair
                if (upd_en)
                begin
                    cmd_pos = hit_pos_reg;
                    if (upd_deg == '0)
                    begin
                        cmd        = smau_pkg::CMD_DROP;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        cmd      = smau_pkg::CMD_SET;
                        bus.deg  = upd_deg;
                        bus.mark = upd_mark;
                    end
                end
                state_next = smau_pkg::S_IDLE;
            end

            smau_pkg::S_PRUNE:
            begin
                if (unm_any)
                begin
                    cmd        = smau_pkg::CMD_DROP;
                    cmd_pos    = unm_pos;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next = smau_pkg::S_EMIT;
                end
            end

            smau_pkg::S_EMIT:
            begin
                strobe_next               = 1'b1;
                result_next.is_divisible  = div_reg;
                result_next.overflow_flag = ovf_reg;
                result_next.order_error   = ord_reg;
                if (n_emit == '0)
                begin
                    emit_last               = 1'b1;
                    result_next.out_index   = '0;
                    result_next.out_degree  = '0;
                    result_next.entry_valid = 1'b0;
                end
                else
                begin
                    emit_last               = ((emit_reg + 1'b1) == n_emit);
                    result_next.out_index   = emit_entry.idx;
                    result_next.out_degree  = emit_entry.deg;
                    result_next.entry_valid = 1'b1;
                end
                result_next.last_entry = emit_last;
                if (emit_last)
                begin
                    div_next    = 1'b1;
                    ovf_next    = 1'b0;
                    ord_next    = 1'b0;
                    prev_next   = smau_pkg::NO_PREV;
                    clear_marks = 1'b1;
                    state_next  = smau_pkg::S_IDLE;
                end
                else
                begin
                    emit_next = emit_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = smau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= smau_pkg::S_IDLE;
            mode_reg   <= smau_pkg::MODE_MUL;
            count_reg  <= '0;
            div_reg    <= 1'b1;
            ovf_reg    <= 1'b0;
            ord_reg    <= 1'b0;
            prev_reg   <= smau_pkg::NO_PREV;
            emit_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            div_reg    <= div_next;
            ovf_reg    <= ovf_next;
            ord_reg    <= ord_next;
            prev_reg   <= prev_next;
            emit_reg   <= emit_next;
            strobe_reg <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= smau_pkg::mode_t'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_v_reg    <= op_v_next;
        op_d_reg    <= op_d_next;
        hit_reg     <= hit_next;
        hit_pos_reg <= hit_pos_next;
        ins_pos_reg <= ins_pos_next;
        cur_deg_reg <= cur_deg_next;
        result_reg  <= result_next;
    end

    assign busy          = (state_reg != smau_pkg::S_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= N)
        else $error("entry count beyond list size");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last_entry |=> result_strobe)
        else $error("result burst broken before last entry");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.entry_valid |-> result.last_entry)
        else $error("empty result not marked last");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.action == smau_pkg::ACT_CLEAR |=> count_reg == '0 && !busy)
        else $error("clear did not empty the list");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.action == smau_pkg::ACT_FINISH |=> busy)
        else $error("finish did not hold the block busy");

endmodule

// File: sim/tb_sparse_monomial_arith_unit_top.sv
module tb_sparse_monomial_arith_unit_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES  = smau_pkg::MAX_ENTRIES;
    localparam int INDEX_BITS   = smau_pkg::INDEX_BITS;
    localparam int DEGREE_BITS  = smau_pkg::DEGREE_BITS;
    localparam int RESULT_LIMIT = smau_pkg::RESULT_LIMIT;
    localparam logic [INDEX_BITS:0] NO_PREV = smau_pkg::NO_PREV;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;
    localparam int ITEM_TARGET   = 300;
    localparam logic [DEGREE_BITS-1:0] DEG_MAX = {DEGREE_BITS{1'b1}};
    localparam logic [INDEX_BITS-1:0]  IDX_MAX = {INDEX_BITS{1'b1}};

    // Tracks the accumulator monomial and the flags of the current run, and
    // queues the terms each finish should emit.
    class term_scoreboard;
        logic [INDEX_BITS-1:0]  acc_idx[MAX_ENTRIES];
        logic [DEGREE_BITS-1:0] acc_deg[MAX_ENTRIES];
        bit                     acc_mark[MAX_ENTRIES];
        int                     acc_count;
        bit                     divisible;
        bit                     saturated;
        bit                     misordered;
        logic [INDEX_BITS:0]    prev_idx;
        smau_pkg::mode_t        mode;
        smau_pkg::out_t         expected_terms[$];
        int                     errors;

        function new();
            acc_count = 0;
            mode      = smau_pkg::MODE_MUL;
            errors    = 0;
            start_run();
        endfunction

        function void start_run();
            int k;
            for (k = 0; k < MAX_ENTRIES; k++)
                acc_mark[k] = 1'b0;
            divisible  = 1'b1;
            saturated  = 1'b0;
            misordered = 1'b0;
            prev_idx   = NO_PREV;
        endfunction

        function int pending();
            return expected_terms.size();
        endfunction

        function void set_mode(smau_pkg::mode_t m);
            mode = m;
        endfunction

        function void remove_at(int p);
            int k;
            for (k = p; k + 1 < acc_count; k++)
            begin
                acc_idx[k]  = acc_idx[k + 1];
                acc_deg[k]  = acc_deg[k + 1];
                acc_mark[k] = acc_mark[k + 1];
            end
            acc_count--;
        endfunction

        function void insert_at(int p, logic [INDEX_BITS-1:0] v,
                                logic [DEGREE_BITS-1:0] d);
            int k;
            for (k = acc_count; k > p; k--)
            begin
                acc_idx[k]  = acc_idx[k - 1];
                acc_deg[k]  = acc_deg[k - 1];
                acc_mark[k] = acc_mark[k - 1];
            end
            acc_idx[p]  = v;
            acc_deg[p]  = d;
            acc_mark[p] = 1'b0;
            acc_count++;
        endfunction

        // any mode: a degree that reaches zero takes the pair out of the list
        function void set_or_remove(int p, logic [DEGREE_BITS-1:0] d);
            if (d == '0)
                remove_at(p);
            else
                acc_deg[p] = d;
        endfunction

        function void apply_operand(logic [INDEX_BITS-1:0] v,
                                    logic [DEGREE_BITS-1:0] d);
            int                   p;
            int                   k;
            logic [DEGREE_BITS:0] sum;
            if (prev_idx != NO_PREV && {1'b0, v} >= prev_idx)
                misordered = 1'b1;
            prev_idx = {1'b0, v};
            p = -1;
            for (k = 0; k < acc_count; k++)
            begin
                if (acc_idx[k] == v)
                begin
                    p = k;
                    break;
                end
            end
            if (p < 0 || acc_deg[p] < d)
                divisible = 1'b0;
            case (mode)
                smau_pkg::MODE_MUL:
                begin
                    if (p >= 0)
                    begin
                        sum = {1'b0, acc_deg[p]} + {1'b0, d};
                        if (sum[DEGREE_BITS])
                        begin
                            sum       = {1'b0, DEG_MAX};
                            saturated = 1'b1;
                        end
                        set_or_remove(p, sum[DEGREE_BITS-1:0]);
                    end
                    else if (d != '0)
                    begin
                        if (acc_count >= MAX_ENTRIES)
                            saturated = 1'b1;
                        else
                        begin
                            k = 0;
                            while (k < acc_count && acc_idx[k] >= v)
                                k++;
                            insert_at(k, v, d);
                        end
                    end
                end
                smau_pkg::MODE_DIV:
                begin
                    if (p >= 0)
                        set_or_remove(p, (acc_deg[p] > d) ? acc_deg[p] - d
                                                          : {DEGREE_BITS{1'b0}});
                end
                smau_pkg::MODE_GCD:
                begin
                    if (p >= 0)
                    begin
                        acc_mark[p] = 1'b1;
                        set_or_remove(p, (acc_deg[p] < d) ? acc_deg[p] : d);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void emit_term();
            int             k;
            int             n;
            smau_pkg::out_t r;
            if (mode == smau_pkg::MODE_GCD)
            begin
                k = 0;
                while (k < acc_count)
                begin
                    if (acc_mark[k])
                        k++;
                    else
                        remove_at(k);
                end
            end
            n = (acc_count < RESULT_LIMIT) ? acc_count : RESULT_LIMIT;
            r = '0;
            r.is_divisible  = divisible;
            r.overflow_flag = saturated;
            r.order_error   = misordered;
            if (n == 0)
            begin
                r.last_entry = 1'b1;
                expected_terms.insert(expected_terms.size(), r);
            end
            for (k = 0; k < n; k++)
            begin
                r.out_index   = acc_idx[k];
                r.out_degree  = acc_deg[k];
                r.entry_valid = 1'b1;
                r.last_entry  = (k == n - 1);
                expected_terms.insert(expected_terms.size(), r);
            end
            start_run();
        endfunction

        function void note_item(smau_pkg::in_t it);
            case (it.action)
                smau_pkg::ACT_CLEAR:
                begin
                    acc_count = 0;
                    start_run();
                end
                smau_pkg::ACT_LOAD:
                begin
                    if (acc_count >= MAX_ENTRIES)
                        saturated = 1'b1;
                    else
                        insert_at(acc_count, it.var_index, it.var_degree);
                end
                smau_pkg::ACT_OPERAND:
                    apply_operand(it.var_index, it.var_degree);
                default:
                    emit_term();
            endcase
        endfunction

        function void check_field(string name, logic [DEGREE_BITS-1:0] want,
                                  logic [DEGREE_BITS-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(smau_pkg::out_t got);
            smau_pkg::out_t want;
            if (expected_terms.size() == 0)
            begin
                $error("result with no term expected: index %0h degree %0h",
                       got.out_index, got.out_degree);
                errors++;
                return;
            end
            want = expected_terms.pop_front();
            check_field("out_index", DEGREE_BITS'(want.out_index),
                        DEGREE_BITS'(got.out_index));
            check_field("out_degree", want.out_degree, got.out_degree);
            check_field("entry_valid", DEGREE_BITS'(want.entry_valid),
                        DEGREE_BITS'(got.entry_valid));
            check_field("is_divisible", DEGREE_BITS'(want.is_divisible),
                        DEGREE_BITS'(got.is_divisible));
            check_field("overflow_flag", DEGREE_BITS'(want.overflow_flag),
                        DEGREE_BITS'(got.overflow_flag));
            check_field("order_error", DEGREE_BITS'(want.order_error),
                        DEGREE_BITS'(got.order_error));
            check_field("last_entry", DEGREE_BITS'(want.last_entry),
                        DEGREE_BITS'(got.last_entry));
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    smau_pkg::in_t  item = '0;
    logic           result_strobe;
    smau_pkg::out_t result;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_data = 2'b00;

    term_scoreboard        sb = new();
    int                    items_sent = 0;
    int                    cycles = 0;
    bit                    gaps_on = 1'b0;
    logic [INDEX_BITS-1:0] pick_q[$];

    sparse_monomial_arith_unit_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // values read here are the ones held before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe === 1'b1)
                sb.check_result(result);
            if (start === 1'b1 && busy === 1'b0)
                sb.note_item(item);
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                sb.set_mode(smau_pkg::mode_t'(cfg_data));
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [INDEX_BITS-1:0] rnd_index();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return IDX_MAX;
        return INDEX_BITS'($urandom);
    endfunction

    function automatic logic [DEGREE_BITS-1:0] rnd_degree();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 30)
            return DEG_MAX;
        if (r < 50)
            return DEGREE_BITS'($urandom);
        return DEGREE_BITS'($urandom_range(1, 20));
    endfunction

    // fills pick_q; well-formed lists are strictly descending
    function automatic void pick_indices(int n, bit from_acc, bit well_formed);
        logic [INDEX_BITS-1:0] raw[$];
        logic [INDEX_BITS-1:0] v;
        int                    k;
        for (k = 0; k < n; k++)
        begin
            if (from_acc && sb.acc_count != 0 && $urandom_range(3) != 0)
                v = sb.acc_idx[$urandom_range(sb.acc_count - 1)];
            else
                v = rnd_index();
            raw.insert(raw.size(), v);
        end
        pick_q.delete();
        if (!well_formed)
            pick_q = raw;
        else
        begin
            raw.rsort();
            foreach (raw[k2])
                if (pick_q.size() == 0 || pick_q[$] != raw[k2])
                    pick_q.insert(pick_q.size(), raw[k2]);
        end
    endfunction

    task automatic send_item(smau_pkg::action_t a, logic [INDEX_BITS-1:0] v,
                             logic [DEGREE_BITS-1:0] d);
        smau_pkg::in_t it;
        if (gaps_on && $urandom_range(99) < 28)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        it.action     = a;
        it.var_index  = v;
        it.var_degree = d;
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
    endtask

    // only with nothing in flight: operands finish in the S_OPER state after acceptance
    task automatic write_mode(smau_pkg::mode_t m);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_items();
        // empty list straight after reset
        send_item(smau_pkg::ACT_FINISH, '0, '0);
        // loads are taken as given, degree zero included
        send_item(smau_pkg::ACT_LOAD, IDX_MAX, DEG_MAX);
        send_item(smau_pkg::ACT_LOAD, 8'd0, 16'd1);
        send_item(smau_pkg::ACT_LOAD, 8'd100, 16'd0);
        send_item(smau_pkg::ACT_LOAD, 8'd40, 16'd7);
        send_item(smau_pkg::ACT_OPERAND, IDX_MAX, 16'd1);  // saturates
        send_item(smau_pkg::ACT_OPERAND, 8'd100, 16'd0);   // sum zero, pair removed
        send_item(smau_pkg::ACT_OPERAND, 8'd50, 16'd0);    // absent, degree zero: no insert
        send_item(smau_pkg::ACT_OPERAND, 8'd60, 16'd3);    // inserted before first lower index
        send_item(smau_pkg::ACT_OPERAND, 8'd60, 16'd2);    // repeated index: order flag
        send_item(smau_pkg::ACT_FINISH, '0, '0);
        write_mode(smau_pkg::MODE_DIV);
        send_item(smau_pkg::ACT_CLEAR, '0, '0);
        send_item(smau_pkg::ACT_LOAD, 8'd200, 16'd5);
        send_item(smau_pkg::ACT_LOAD, 8'd10, DEG_MAX);
        send_item(smau_pkg::ACT_OPERAND, 8'd200, 16'd9);   // clamps at zero, removed
        send_item(smau_pkg::ACT_OPERAND, 8'd150, 16'd1);   // absent, ignored
        // mode switched in the middle of a run
        write_mode(smau_pkg::MODE_GCD);
        send_item(smau_pkg::ACT_OPERAND, 8'd10, 16'd3);
        send_item(smau_pkg::ACT_LOAD, 8'd5, 16'd2);        // never matched, pruned at finish
        send_item(smau_pkg::ACT_FINISH, IDX_MAX, DEG_MAX);
        write_mode(smau_pkg::MODE_TEST);
        send_item(smau_pkg::ACT_OPERAND, 8'd10, 16'd3);
        send_item(smau_pkg::ACT_OPERAND, 8'd0, 16'd0);
        send_item(smau_pkg::ACT_FINISH, '0, '0);
    endtask

    task automatic random_run();
        int n_load;
        int n_op;
        int k;
        if ($urandom_range(99) < 30)
            write_mode(smau_pkg::mode_t'($urandom_range(3)));
        if ($urandom_range(99) < 80)
            send_item(smau_pkg::ACT_CLEAR, rnd_index(), rnd_degree());
        // now and then fill the list past its capacity
        n_load = ($urandom_range(99) < 10) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        pick_indices(n_load, 1'b0, $urandom_range(99) < 90);
        for (k = 0; k < pick_q.size(); k++)
            send_item(smau_pkg::ACT_LOAD, pick_q[k], rnd_degree());
        n_op = $urandom_range(0, 5);
        pick_indices(n_op, 1'b1, $urandom_range(99) < 85);
        for (k = 0; k < pick_q.size(); k++)
        begin
            send_item(smau_pkg::ACT_OPERAND, pick_q[k], rnd_degree());
            if ($urandom_range(99) < 4)
                write_mode(smau_pkg::mode_t'($urandom_range(3)));
        end
        if ($urandom_range(99) < 10)
            send_item(smau_pkg::action_t'($urandom_range(3)), rnd_index(), rnd_degree());
        send_item(smau_pkg::ACT_FINISH, rnd_index(), rnd_degree());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        directed_items();
        // extremes of the register, then random settings per run
        write_mode(smau_pkg::MODE_TEST);
        write_mode(smau_pkg::MODE_MUL);
        while (items_sent < ITEM_TARGET)
        begin
            gaps_on = (items_sent < 120 || items_sent > 200);
            random_run();
        end
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
